// ----- rtl/core/pcrm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_pkg: shared constants and types for the per-client rate monitor
// Holds the default sizes, saturation limits and action codes.
// ----------------------------------------------------------------------------
package pcrm_pkg;
  localparam int DefClients = 16;
  localparam int DefWindow  = 10;

  localparam int GapW    = 16;
  localparam int SumW    = 20;
  localparam int ThrW    = 10;
  localparam int FactorW = 16;
  localparam int NumW    = 18;   // n * 16384 fits in 18 bits for n <= 15
  localparam int DenW    = 14;   // T * n < 2^14

  localparam logic [FactorW-1:0] FactorMax = 16'd49152;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SLOW = 2'd1,
    ACT_STOP = 2'd2
  } action_t;
endpackage
`default_nettype wire

// ----- rtl/core/pcrm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcrm_div: restoring divider, one quotient bit per cycle
// Divides an 18-bit numerator by a 14-bit nonzero denominator.
// ----------------------------------------------------------------------------
module pcrm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [pcrm_pkg::NumW-1:0]     num,
  input  wire logic [pcrm_pkg::DenW-1:0]     den,
  output logic                               done,
  output logic [pcrm_pkg::NumW-1:0]          quot
);
  import pcrm_pkg::*;

  logic [NumW-1:0]  q;
  logic [DenW-1:0]  rem;
  logic [DenW-1:0]  d;
  logic [4:0]       cnt;
  logic             run;
  logic [DenW:0]    trial;
  logic [DenW:0]    shifted;

  // The partial remainder stays below the denominator, so it fits in DenW bits.
  assign shifted = {rem, q[NumW-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(NumW);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= num;
      d   <= den;
      rem <= '0;
    end else if (run) begin
      if (!trial[DenW]) begin
        rem <= trial[DenW-1:0];
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted[DenW-1:0];
        q   <= {q[NumW-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
endmodule
`default_nettype wire

// ----- rtl/core/per_client_rate_monitor_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_client_rate_monitor_core: per-client message rate monitor
// Tracks gaps between arrivals per client and orders slow or stop notices.
// ----------------------------------------------------------------------------
// An item (client index and time in seconds) is taken when start is high and
// busy is low. Exactly one result follows per item, shown on action and
// pace_factor for one cycle with done high; the receiver cannot stall it, so
// it must take every done pulse. When a slow-down is ordered, the item also
// waits on the shared bit-serial divider that forms the factor one quotient
// bit per cycle. The gap window memory is read and written through one port,
// so the oldest gap is read in its own cycle before the new gap is stored. An
// index at or beyond CLIENTS gives action none and changes nothing. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module per_client_rate_monitor_core #(
  parameter int CLIENTS = pcrm_pkg::DefClients,
  parameter int WINDOW  = pcrm_pkg::DefWindow
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [3:0]                    client_index,
  input  wire logic [31:0]                   now_seconds,
  input  wire logic                          cfg_we,
  input  wire logic [pcrm_pkg::ThrW-1:0]     cfg_data,
  output logic                               done,
  output logic [1:0]                         action,
  output logic [pcrm_pkg::FactorW-1:0]       pace_factor
);
  import pcrm_pkg::*;

  localparam int CW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int Deep = CLIENTS * WINDOW;
  localparam int AW   = $clog2(Deep);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_UPD   = 6'b000100,
    S_DEC   = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic [ThrW-1:0] rate_threshold;

  // Per-client control state, one entry per client in flip-flops.
  logic [CLIENTS-1:0] seen_flag;
  logic [CLIENTS-1:0] slowed_flag;
  logic [31:0]        last_arrival [CLIENTS];
  logic [3:0]         window_head  [CLIENTS];
  logic [3:0]         window_count [CLIENTS];
  logic [SumW-1:0]    gap_sum      [CLIENTS];

  logic [GapW-1:0]    gap_window [Deep];
  logic [GapW-1:0]    old_gap;

  logic [CW-1:0]      cid;
  logic [31:0]        now_r;
  logic [GapW-1:0]    gap;
  logic [3:0]         n_new;
  logic [SumW-1:0]    sum_new;
  logic [DenW-1:0]    limit;
  logic [DenW-1:0]    lim_full;
  logic [1:0]         act_r;
  logic [FactorW-1:0] fac_r;
  logic               full;
  logic [3:0]         head;
  logic [3:0]         slot_off;
  logic [AW-1:0]      slot;
  logic [31:0]        diff;
  logic [4:0]         hn;

  logic               div_go;
  logic               div_done;
  logic [NumW-1:0]    div_q;

  assign busy = (state != S_IDLE);
  wire in_range = ({28'd0, client_index} < 32'(CLIENTS));

  // Threshold times window fill; at most 1023 * 15, so it fits in DenW bits.
  assign lim_full = DenW'(rate_threshold) * DenW'(n_new);

  always_comb begin
    head = (window_head[cid] >= 4'(WINDOW)) ? 4'd0 : window_head[cid];
    full = (window_count[cid] >= 4'(WINDOW));
    hn   = {1'b0, head} + {1'b0, window_count[cid]};
    if (full) slot_off = head;
    else if (hn >= 5'(WINDOW)) slot_off = 4'(hn - 5'(WINDOW));
    else slot_off = hn[3:0];
    slot = AW'(cid * WINDOW) + AW'(slot_off);
    diff = now_r - last_arrival[cid];
    if (!seen_flag[cid]) gap = '0;
    else if (diff[31:16] != 16'd0) gap = 16'hFFFF;
    else gap = diff[15:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) old_gap <= gap_window[slot];
    if (state == S_UPD) gap_window[slot] <= gap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rate_threshold <= ThrW'(2);
      seen_flag      <= '0;
      slowed_flag    <= '0;
      done           <= 1'b0;
      div_go         <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        last_arrival[i] <= '0;
        window_head[i]  <= '0;
        window_count[i] <= '0;
        gap_sum[i]      <= '0;
      end
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      if (cfg_we) rate_threshold <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            cid   <= CW'(client_index);
            now_r <= now_seconds;
            act_r <= ACT_NONE;
            fac_r <= '0;
            state <= in_range ? S_READ : S_OUT;
          end
        end
        S_READ: state <= S_UPD;
        S_UPD: begin
          if (full) begin
            sum_new <= gap_sum[cid] - SumW'(old_gap) + SumW'(gap);
            gap_sum[cid] <= gap_sum[cid] - SumW'(old_gap) + SumW'(gap);
            window_head[cid] <= (head + 4'd1 >= 4'(WINDOW)) ? 4'd0 : head + 4'd1;
            n_new <= 4'(WINDOW);
            window_count[cid] <= 4'(WINDOW);
          end else begin
            sum_new <= gap_sum[cid] + SumW'(gap);
            gap_sum[cid] <= gap_sum[cid] + SumW'(gap);
            window_head[cid] <= head;
            n_new <= window_count[cid] + 4'd1;
            window_count[cid] <= window_count[cid] + 4'd1;
          end
          seen_flag[cid]    <= 1'b1;
          last_arrival[cid] <= now_r;
          state <= S_DEC;
        end
        S_DEC: begin
          // limit is latched here; the divider starts on the next edge.
          if (!slowed_flag[cid] && sum_new < SumW'(lim_full)) begin
            limit <= lim_full - sum_new[DenW-1:0];
            slowed_flag[cid] <= 1'b1;
            act_r  <= ACT_SLOW;
            div_go <= 1'b1;
            state  <= S_DIV;
          end else begin
            if (slowed_flag[cid] && sum_new > SumW'(lim_full)) begin
              slowed_flag[cid] <= 1'b0;
              act_r <= ACT_STOP;
            end
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fac_r <= (div_q > NumW'(FactorMax)) ? FactorMax : FactorW'(div_q);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      action      <= act_r;
      pace_factor <= fac_r;
    end
  end

  pcrm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  ({n_new, 14'd0}),
    .den  (limit),
    .done (div_done),
    .quot (div_q)
  );

`ifndef SYNTHESIS
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> done) else $error("result strobe missing");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_go |-> limit != '0) else $error("divide by zero");
`endif
endmodule
`default_nettype wire

// ----- test/per_client_rate_monitor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_client_rate_monitor_checker: result checker for the rate monitor
// Follows the item and configuration channels, keeps its own per-client gap
// windows, predicts action and slow factor, and compares them with each result.
// ----------------------------------------------------------------------------
module per_client_rate_monitor_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [3:0]  client_index,
  input  wire logic [31:0] now_seconds,
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        done,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] pace_factor,
  output int               fail_count,
  output int               pending_count
);
  import pcrm_pkg::*;

  localparam int Clients = 16;
  localparam int Win     = 10;

  typedef struct packed {
    action_t     act;
    logic [15:0] factor;
  } notice_t;

  notice_t      notice_q[$];
  logic [9:0]   thresh;
  bit           seen[Clients];
  logic [31:0]  last_t[Clients];
  logic [15:0]  gaps[Clients][Win];
  int unsigned  head_ptr[Clients];
  int unsigned  fill[Clients];
  logic [19:0]  sum_of_gaps[Clients];
  bit           slowed[Clients];

  assign pending_count = notice_q.size();

  function automatic notice_t rate_decision(input logic [3:0] c, input logic [31:0] t);
    notice_t     r;
    logic [31:0] gap;
    int unsigned n, lim, q;
    r.act = ACT_NONE;
    r.factor = '0;
    if (c >= Clients) return r;
    gap = seen[c] ? t - last_t[c] : 32'd0;
    if (gap > 32'd65535) gap = 32'd65535;
    seen[c] = 1'b1;
    last_t[c] = t;
    n = fill[c];
    if (n >= Win) begin
      sum_of_gaps[c] = sum_of_gaps[c] - gaps[c][head_ptr[c]];
      gaps[c][head_ptr[c]] = gap[15:0];
      head_ptr[c] = (head_ptr[c] + 1) % Win;
    end else begin
      gaps[c][(head_ptr[c] + n) % Win] = gap[15:0];
      fill[c] = n + 1;
    end
    n = fill[c];
    sum_of_gaps[c] = sum_of_gaps[c] + gap[19:0];
    lim = thresh * n;
    if (!slowed[c] && sum_of_gaps[c] < lim) begin
      q = (n * 16384) / (lim - sum_of_gaps[c]);
      r.factor = (q > 49152) ? 16'd49152 : q[15:0];
      r.act = ACT_SLOW;
      slowed[c] = 1'b1;
    end else if (slowed[c] && sum_of_gaps[c] > lim) begin
      slowed[c] = 1'b0;
      r.act = ACT_STOP;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    notice_t want;
    if (rst) begin
      thresh <= 10'd2;
      for (int i = 0; i < Clients; i++) begin
        seen[i] = 0; last_t[i] = 0; head_ptr[i] = 0; fill[i] = 0;
        sum_of_gaps[i] = 0; slowed[i] = 0;
      end
      notice_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) thresh <= cfg_data;
      if (start && !busy) notice_q.push_back(rate_decision(client_index, now_seconds));
      if (done) begin
        if (notice_q.size() == 0) begin
          $display("%0t: result with nothing expected: got action %0d factor %0d",
                   $time, action, pace_factor);
          fail_count <= fail_count + 1;
        end else begin
          want = notice_q.pop_front();
          if (action !== want.act || pace_factor !== want.factor) begin
            $display("%0t: expected action %0d factor %0d, got action %0d factor %0d",
                     $time, want.act, want.factor, action, pace_factor);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- test/tb_per_client_rate_monitor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_client_rate_monitor_core: testbench for the per-client rate monitor
// Drives directed and random arrivals under several thresholds and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_per_client_rate_monitor_core;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  client_index = '0;
  logic [31:0] now_seconds = '0;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_data = '0;
  logic        busy, done;
  logic [1:0]  action;
  logic [15:0] pace_factor;
  int          fail_count, pending_count;

  // Each client has its own clock so random times form sensible gap streams.
  logic [31:0] client_time[16];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  per_client_rate_monitor_core i_dut (
    .clk, .rst, .start, .busy, .client_index, .now_seconds,
    .cfg_we, .cfg_data, .done, .action, .pace_factor
  );

  per_client_rate_monitor_checker i_checker (
    .clk, .rst, .start, .busy, .client_index, .now_seconds,
    .cfg_we, .cfg_data, .done, .action, .pace_factor,
    .fail_count, .pending_count
  );

  // Present one arrival at the falling edge and hold it until the block takes
  // it. Start stays high across back-to-back items in a burst.
  task automatic send_arrival(input logic [3:0] c, input logic [31:0] t);
    start <= 1'b1;
    client_index <= c;
    now_seconds <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Registers are written only with the block idle. Every item has a result,
  // so an empty expectation queue plus a short margin is enough.
  task automatic set_threshold(input logic [9:0] value);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small gaps near the threshold, so slow and stop notices alternate;
  // some large or wrapping jumps exercise saturation.
  task automatic random_arrival(input int thr);
    logic [3:0]  c;
    logic [31:0] step;
    c = 4'($urandom_range(15));
    case ($urandom_range(9))
      0: step = $urandom();
      1: step = $urandom_range(70000, 60000);
      default: step = $urandom_range(2 * thr + 2);
    endcase
    client_time[c] = client_time[c] + step;
    send_arrival(c, client_time[c]);
  endtask

  initial begin
    int thr_list[5];
    thr_list = '{0, 1, 999, 5, 1023};
    for (int i = 0; i < 16; i++) client_time[i] = $urandom();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset threshold of 2, first sight, zero gaps give slow,
    // saturated gap gives stop, wrapping time, equal-average case.
    send_arrival(4'd0, 32'd0);
    send_arrival(4'd0, 32'd0);
    send_arrival(4'd0, 32'hFFFF_FFFF);
    send_arrival(4'd0, 32'd3);
    send_arrival(4'd15, 32'hFFFF_FFFF);
    send_arrival(4'd15, 32'h0000_0001);
    send_arrival(4'd15, 32'h0000_0003);
    for (int k = 0; k < 12; k++) send_arrival(4'd7, 32'd100 + 2 * k);
    send_arrival(4'd1, 32'h5555_5555);
    send_arrival(4'd1, 32'hAAAA_AAAA);
    idle_gap(3);

    for (int p = 0; p < 5; p++) begin
      set_threshold(thr_list[p][9:0]);
      for (int k = 0; k < 90; k++) begin
        random_arrival(thr_list[p] > 40 ? 40 : thr_list[p]);
        if ($urandom_range(3) == 0) idle_gap(int'($urandom_range(40)));
      end
    end

    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
